// File: src/sorted_priority_stack_assert.svh
// ---------------------------------------------------------------------------
// Sorted priority stack assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_STACK_ASSERT_SVH
`define SORTED_PRIORITY_STACK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority stack check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority stack check failed");

`endif

// File: src/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types, operation and status codes shared by the sorted priority stack.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH   = 64;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 6;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] val;
    } cell_cmd_t;

endpackage

// File: src/sorted_priority_stack.sv
// Result: registered, valid in the cycle after its input beat is accepted.
// Throughput: one operation per cycle; every cell of the chain compares and
// shifts in the same cycle, and a stalled output register frees on the next take.
// Read path: a select over the first 64 cells, set by the 6-bit index.
// Reset: count and output valid clear at once; cell contents are undefined.
// ---------------------------------------------------------------------------
// sorted_priority_stack
// Descending sorted list built as a chain of compare-and-shift cells, with
// push, pop-largest and read-at-index operations and one result per beat.
// ---------------------------------------------------------------------------
module sorted_priority_stack
#(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [37:32] index, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int CMPW     = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int READSPAN = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic signed [VALUE_W-1:0] rv_reg;
    logic signed [VALUE_W-1:0] rv_next;
    logic [COUNT_OUT_W-1:0]    cnt_out_reg;
    logic [COUNT_OUT_W-1:0]    cnt_out_next;
    status_t                   status_reg;
    status_t                   status_next;

    logic                      accept;
    kind_t                     kind;
    logic signed [VALUE_W-1:0] in_value;
    logic [INDEX_W-1:0]        in_index;
    logic                      full;
    logic                      empty;
    logic                      out_of_range;
    logic signed [VALUE_W-1:0] sel_value;
    cell_cmd_t                 cmd;

    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic                      cell_stays [DEPTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_index = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

    assign full         = (count_reg == CW'(DEPTH));
    assign empty        = (count_reg == '0);
    assign out_of_range = (CMPW'(in_index) >= CMPW'(count_reg));

    assign cmd.push = accept && (kind == KIND_PUSH) && !full;
    assign cmd.pop  = accept && (kind == KIND_POP) && !empty;
    assign cmd.val  = in_value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                      prev_stays;
            logic signed [VALUE_W-1:0] prev_value;
            logic signed [VALUE_W-1:0] next_value;

            if (g == 0)
            begin : g_head
                assign prev_stays = 1'b1;
                assign prev_value = in_value;
            end
            else
            begin : g_body
                assign prev_stays = cell_stays[g-1];
                assign prev_value = cell_value[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_value = cell_value[g];
            end
            else
            begin : g_inner
                assign next_value = cell_value[g+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (CW'(g) < count_reg),
                .prev_stays (prev_stays),
                .prev_value (prev_value),
                .next_value (next_value),
                .value      (cell_value[g]),
                .stays      (cell_stays[g])
            );
        end
    endgenerate

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < READSPAN; i++)
        begin
            if (in_index == INDEX_W'(i))
            begin
                sel_value = cell_value[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        rv_next     = '0;
        status_next = ST_OK;
        case (kind)
            KIND_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (out_of_range)
                begin
                    status_next = ST_RANGE;
                    rv_next     = '1;
                end
                else
                begin
                    rv_next = sel_value;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        cnt_out_next = COUNT_OUT_W'(count_next);
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rv_reg      <= rv_next;
            cnt_out_reg <= cnt_out_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, rv_reg};
    assign m_tuser  = status_reg;

endmodule

// File: src/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against a pushed
// value, and takes a new entry from the push value or a neighbor.
// ---------------------------------------------------------------------------
module spq_cell
(
    input  logic                               clk,
    input  spq_pkg::cell_cmd_t                 cmd,
    input  logic                               occupied,
    input  logic                               prev_stays,
    input  logic signed [spq_pkg::VALUE_W-1:0] prev_value,
    input  logic signed [spq_pkg::VALUE_W-1:0] next_value,
    output logic signed [spq_pkg::VALUE_W-1:0] value,
    output logic                               stays
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // Entry strictly larger than the pushed value keeps its place
    assign stays = occupied && (value_reg > cmd.val);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.push)
        begin
            if (!stays)
            begin
                // first cell that gives way takes the new value, the rest shift down
                value_next = prev_stays ? cmd.val : prev_value;
            end
        end
        else if (cmd.pop)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: src/spq_check.sv
// ---------------------------------------------------------------------------
// spq_check
// Port-level checks on result beats of the sorted priority stack, attached
// to the top level by a bind statement.
// ---------------------------------------------------------------------------
`include "sorted_priority_stack_assert.svh"

module spq_check
#(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import spq_pkg::*;

    // Stalled result beat holds its payload
    `SPQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // Out-of-range read returns all ones
    `SPQ_ASSERT_SAME(a_range_value, m_tvalid && (m_tuser == ST_RANGE), m_tdata[31:0] == '1)

    // Empty status only with no entries stored and no data
    `SPQ_ASSERT_SAME(a_empty_count, m_tvalid && (m_tuser == ST_EMPTY),
        (m_tdata[38:32] == '0) && (m_tdata[31:0] == '0))

    // Rejected push only at full capacity
    `SPQ_ASSERT_SAME(a_full_count, m_tvalid && (m_tuser == ST_FULL),
        m_tdata[38:32] == COUNT_OUT_W'(DEPTH))

endmodule

bind sorted_priority_stack spq_check #(.DEPTH(DEPTH)) u_spq_check (.*);

// File: verif/sorted_priority_stack_test.sv
// ---------------------------------------------------------------------------
// sorted_priority_stack_test
// Self-checking bench for the sorted priority stack. A short table of
// directed operations covers the empty, range and extreme-value cases; then
// phases of push-heavy, mixed and pop-heavy random traffic fill the list to
// full, hold it there and drain it to empty. Typed table rows are checked
// against their row; other result beats against a behavioral sorted list copy.
// ---------------------------------------------------------------------------
module sorted_priority_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int RANDOM_OPS  = 1250;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]    count;
        status_t                   status;
    } stack_result_t;

    typedef struct {
        kind_t                     kind;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
        bit                        typed;
        stack_result_t             want;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [31:0] value, [37:32] index, [39:38] zero
    logic [1:0]  s_tuser = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] read_value, [38:32] count, [39] zero
    logic [1:0]  m_tuser;        // [1:0] status

    logic signed [VALUE_W-1:0] sorted_list[$];
    stack_result_t             pending_results[$];
    op_row_t                   op_table[$];
    int                        mismatches = 0;
    int                        cycle_count = 0;
    logic                      calm = 1'b0;

    sorted_priority_stack dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Apply one operation to the local sorted list and give its result.
    task automatic predict_stack_op(input kind_t k, input logic signed [VALUE_W-1:0] v,
                                    input logic [INDEX_W-1:0] idx,
                                    output stack_result_t r);
        int p;
        begin
            r.read_value = '0;
            r.status     = ST_OK;
            case (k)
                KIND_PUSH:
                begin
                    if (sorted_list.size() >= SPQ_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        p = 0;
                        // land ahead of the first entry less than or equal
                        while (p < sorted_list.size() && !(v >= sorted_list[p]))
                            p++;
                        sorted_list.insert(p, v);
                    end
                end
                KIND_POP:
                begin
                    if (sorted_list.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        void'(sorted_list.pop_front());
                end
                KIND_READ:
                begin
                    if (sorted_list.size() == 0)
                        r.status = ST_EMPTY;
                    else if (idx >= sorted_list.size())
                    begin
                        r.status     = ST_RANGE;
                        r.read_value = -1;
                    end
                    else
                        r.read_value = sorted_list[idx];
                end
                default: ;
            endcase
            r.count = COUNT_OUT_W'(sorted_list.size());
        end
    endtask

    // Offer one input beat, hold it until taken, then log its expectation.
    task automatic send_op(input kind_t k, input logic signed [VALUE_W-1:0] v,
                           input logic [INDEX_W-1:0] idx, input bit typed,
                           input stack_result_t want);
        stack_result_t got;
        begin
            if (!calm && $urandom_range(99) < 8)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(3, 1)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= k;
            s_tdata  <= {2'b00, idx, v};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_stack_op(k, v, idx, got);
            pending_results.push_back(typed ? want : got);
        end
    endtask

    function automatic op_row_t row(input kind_t k, input logic signed [VALUE_W-1:0] v,
                                    input logic [INDEX_W-1:0] idx, input bit typed,
                                    input logic signed [VALUE_W-1:0] rv,
                                    input logic [COUNT_OUT_W-1:0] cnt, input status_t st);
        op_row_t r;
        r.kind  = k;
        r.value = v;
        r.index = idx;
        r.typed = typed;
        r.want  = '{read_value: rv, count: cnt, status: st};
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom;
        else if (r < 70)
            return $signed($urandom_range(15)) - 8;   // crowd equal values
        else if (r < 85 || sorted_list.size() == 0)
        begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        else
            return sorted_list[$urandom_range(sorted_list.size() - 1)];
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 40 || sorted_list.size() == 0)
            return INDEX_W'($urandom_range(SPQ_DEPTH - 1));
        else if (r < 80)
            return INDEX_W'($urandom_range(sorted_list.size() - 1));
        else
            return INDEX_W'(sorted_list.size());      // first index past the end
    endfunction

    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        stack_result_t got;
        if (m_tvalid && m_tready)
        begin
            got = '{read_value: m_tdata[31:0], count: m_tdata[38:32],
                    status: status_t'(m_tuser)};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: value %0d count %0d status %0d",
                         $time, got.read_value, got.count, got.status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, want.read_value, got.read_value);
                    mismatches++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    mismatches++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 8);
    end

    initial
    begin : stimulus
        int            n;
        int            r;
        int            phase;
        kind_t         k;
        stack_result_t none;

        none = '0;
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd0,  1, 0, 0, ST_EMPTY));
        op_table.push_back(row(KIND_POP,  32'shFFFF_FFFF, 6'd63, 1, 0, 0, ST_EMPTY));
        op_table.push_back(row(KIND_READ, 32'sh5555_5555, 6'd63, 1, 0, 0, ST_EMPTY));
        op_table.push_back(row(KIND_PUSH, 32'sh7FFF_FFFF, 6'd0,  1, 0, 1, ST_OK));
        op_table.push_back(row(KIND_PUSH, 32'sh8000_0000, 6'd63, 1, 0, 2, ST_OK));
        op_table.push_back(row(KIND_PUSH, 32'sh0000_0000, 6'd21, 1, 0, 3, ST_OK));
        op_table.push_back(row(KIND_PUSH, 32'sh0000_0000, 6'd42, 0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_PUSH, 32'shFFFF_FFFF, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_PUSH, 32'sh7FFF_FFFF, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_READ, 32'shAAAA_AAAA, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd1,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd5,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd6,  1, -1, 6, ST_RANGE));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd63, 1, -1, 6, ST_RANGE));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  1, 0, 5, ST_OK));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd0,  0, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  1, 0, 0, ST_OK));
        op_table.push_back(row(KIND_POP,  32'sh0000_0000, 6'd0,  1, 0, 0, ST_EMPTY));
        op_table.push_back(row(KIND_READ, 32'sh0000_0000, 6'd0,  1, 0, 0, ST_EMPTY));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (op_table[i])
            send_op(op_table[i].kind, op_table[i].value, op_table[i].index,
                    op_table[i].typed, op_table[i].want);

        // Phases of 100 beats: fill, hold at full, mixed, drain.
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            calm <= (n >= 500 && n < 800);
            phase = (n / 100) % 4;
            r = $urandom_range(99);
            case (phase)
                0, 1:    k = (r < 85) ? KIND_PUSH : (r < 90) ? KIND_POP : KIND_READ;
                2:       k = (r < 35) ? KIND_PUSH : (r < 65) ? KIND_POP : KIND_READ;
                default: k = (r < 10) ? KIND_PUSH : (r < 80) ? KIND_POP : KIND_READ;
            endcase
            send_op(k, pick_value(), pick_index(), 1'b0, none);
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
